// ===== src/tcst_pkg.sv =====
// Shared types and field widths of the timed command schedule table.
package tcst_pkg;

    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int BYTE_W     = 8;
    localparam int REQ_TIME_W = 32;
    localparam int OUT_TIME_W = 32;

    // Input tdata: use_next_slot, req_time, cmd_code, padded to whole bytes.
    localparam int S_TDATA_W  = 48;
    // Output tdata: found_byte, next_free_time.
    localparam int M_TDATA_W  = 40;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_DEFERRED = 2'd1,
        STAT_REJECTED = 2'd2,
        STAT_MISS     = 2'd3
    } status_t;

    typedef enum logic {
        FSM_IDLE   = 1'b0,
        FSM_SEARCH = 1'b1
    } fsm_t;

endpackage

// ===== src/timed_command_schedule_table_core.sv =====
// Top level of the timed command schedule table: request decode, search sequencer, result register.
//
// Usage:
// Requests enter on the s_axis channel; tuser carries the request kind (append, lookup,
// clear) and tdata carries use_next_slot, req_time and cmd_code. Each request gives
// exactly one result on the m_axis channel: status in tuser, found_byte and
// next_free_time in tdata.
// Append, clear and the unused kind finish in the cycle they are accepted; the result is
// valid on the next cycle. An append uses the last stored time held in a register and
// writes one RAM entry, so it never waits on a read.
// A lookup is a binary search over the stored entries, one RAM probe per cycle with the
// next address computed from the compare of the probe that just returned. Its result
// appears once a probe matches the key or the interval closes without a match; an empty
// table answers a lookup with a miss on the next cycle.
// One request is worked on at a time. A new request is taken while the block is idle
// and the result register is empty or being read in the same cycle, so a stalled
// receiver holds the result and stops further requests without losing anything.
// Reset empties the table; the RAM contents are not cleared and need no clearing pass.
module timed_command_schedule_table_core
    import tcst_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int TIME_BITS   = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [0] use_next_slot, [32:1] req_time, [40:33] cmd_code, [47:41] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [REQ_W-1:0]     s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] found_byte, [39:8] next_free_time
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [STATUS_W-1:0]  m_axis_tuser
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = TIME_BITS + BYTE_W;

    // Request fields.
    logic                  in_next_slot;
    logic [REQ_TIME_W-1:0] in_time;
    logic [BYTE_W-1:0]     in_byte;
    logic [TIME_BITS-1:0]  in_key;
    logic                  s_fire;

    // State.
    fsm_t                  state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [TIME_BITS-1:0]  last_time_reg, last_time_next;
    logic [TIME_BITS-1:0]  key_reg, key_next;
    logic [CW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic [CW-1:0]         mid_reg, mid_next;

    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [BYTE_W-1:0]     m_byte_reg, m_byte_next;
    logic [OUT_TIME_W-1:0] m_nft_reg, m_nft_next;

    // RAM interface.
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [EW-1:0]         ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [EW-1:0]         ram_rdata;

    // Append datapath.
    logic                  tbl_full;
    logic                  time_spent;
    logic [TIME_BITS-1:0]  slot_time;
    logic [TIME_BITS-1:0]  app_time;
    logic                  app_deferred;
    logic [63:0]           app_nft_wide;
    logic [OUT_TIME_W-1:0] app_nft;

    // Search datapath.
    logic [TIME_BITS-1:0]  probe_time;
    logic [BYTE_W-1:0]     probe_byte;
    logic                  probe_hit;
    logic                  probe_up;
    logic [CW-1:0]         srch_lo;
    logic [CW-1:0]         srch_hi;
    logic                  srch_miss;
    logic [CW-1:0]         srch_mid;

    // Result load.
    logic                  res_load;
    status_t               res_status;
    logic [BYTE_W-1:0]     res_byte;
    logic [OUT_TIME_W-1:0] res_nft;

    assign in_next_slot = s_axis_tdata[0];
    assign in_time      = s_axis_tdata[REQ_TIME_W:1];
    assign in_byte      = s_axis_tdata[REQ_TIME_W+BYTE_W:REQ_TIME_W+1];
    assign in_key       = TIME_BITS'(in_time);

    assign s_axis_tready = (state_reg == FSM_IDLE) && (!m_valid_reg || m_axis_tready);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {m_nft_reg, m_byte_reg};

    tcst_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Append: the new time is never below the last stored time plus one.
    always_comb
    begin
        tbl_full     = (count_reg == CW'(TABLE_DEPTH));
        time_spent   = (count_reg != '0) && (last_time_reg == '1);
        slot_time    = (count_reg == '0) ? '0 : last_time_reg + TIME_BITS'(1);
        app_deferred = 1'b0;
        if (in_next_slot)
        begin
            app_time = slot_time;
        end
        else if (in_key < slot_time)
        begin
            app_time     = slot_time;
            app_deferred = 1'b1;
        end
        else
        begin
            app_time = in_key;
        end
        app_nft_wide = 64'(app_time) + 64'd1;
        app_nft      = (|app_nft_wide[63:OUT_TIME_W]) ? '1 : app_nft_wide[OUT_TIME_W-1:0];
    end

    // One search step: compare the returned probe and narrow the interval.
    always_comb
    begin
        probe_time = ram_rdata[EW-1:BYTE_W];
        probe_byte = ram_rdata[BYTE_W-1:0];
        probe_hit  = (probe_time == key_reg);
        probe_up   = (probe_time < key_reg);
        srch_lo    = probe_up ? mid_reg + CW'(1) : lo_reg;
        srch_hi    = probe_up ? hi_reg : mid_reg;
        srch_miss  = (srch_lo >= srch_hi);
        srch_mid   = srch_lo + ((srch_hi - srch_lo) >> 1);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (s_fire && (s_axis_tuser == REQ_LOOKUP) && (count_reg != '0))
                begin
                    state_next = FSM_SEARCH;
                end
            end
            FSM_SEARCH:
            begin
                if (probe_hit || srch_miss)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Datapath control and register updates.
    always_comb
    begin
        count_next     = count_reg;
        last_time_next = last_time_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = {app_time, in_byte};
        ram_raddr      = mid_reg[AW-1:0];
        res_load       = 1'b0;
        res_status     = STAT_OK;
        res_byte       = '0;
        res_nft        = '0;

        case (state_reg)
            FSM_IDLE:
            begin
                if (s_fire)
                begin
                    res_load = 1'b1;
                    case (s_axis_tuser)
                        REQ_APPEND:
                        begin
                            if (tbl_full || time_spent)
                            begin
                                res_status = STAT_REJECTED;
                            end
                            else
                            begin
                                ram_we         = 1'b1;
                                count_next     = count_reg + CW'(1);
                                last_time_next = app_time;
                                res_status     = app_deferred ? STAT_DEFERRED : STAT_OK;
                                res_nft        = app_nft;
                            end
                        end
                        REQ_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = STAT_MISS;
                            end
                            else
                            begin
                                res_load  = 1'b0;
                                key_next  = in_key;
                                lo_next   = '0;
                                hi_next   = count_reg;
                                mid_next  = count_reg >> 1;
                                ram_raddr = mid_next[AW-1:0];
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            res_status = STAT_OK;
                        end
                    endcase
                end
            end
            FSM_SEARCH:
            begin
                if (probe_hit)
                begin
                    res_load   = 1'b1;
                    res_status = STAT_OK;
                    res_byte   = probe_byte;
                end
                else if (srch_miss)
                begin
                    res_load   = 1'b1;
                    res_status = STAT_MISS;
                end
                else
                begin
                    lo_next   = srch_lo;
                    hi_next   = srch_hi;
                    mid_next  = srch_mid;
                    ram_raddr = srch_mid[AW-1:0];
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // Result register.
    always_comb
    begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_byte_next   = m_byte_reg;
        m_nft_next    = m_nft_reg;
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (res_load)
        begin
            m_valid_next  = 1'b1;
            m_status_next = res_status;
            m_byte_next   = res_byte;
            m_nft_next    = res_nft;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FSM_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_time_reg <= last_time_next;
        key_reg       <= key_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        m_status_reg  <= m_status_next;
        m_byte_reg    <= m_byte_next;
        m_nft_reg     <= m_nft_next;
    end

    // The entry count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // While searching, the interval is never empty and the probe lies inside it.
    a_search_interval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_SEARCH) |-> (lo_reg <= mid_reg) && (mid_reg < hi_reg))
        else $error("search interval out of order");

    // The result register stays empty while a lookup is in progress.
    a_search_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_SEARCH) |-> !m_valid_reg)
        else $error("result present during search");

    // A clear leaves an empty table.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (s_axis_tuser == REQ_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty the table");

    // Every accepted request other than a lookup on a filled table answers next cycle.
    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && !((s_axis_tuser == REQ_LOOKUP) && (count_reg != '0))) |=> m_valid_reg)
        else $error("single-cycle request gave no result");

    // Appends are never written while the table is full.
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (count_reg < CW'(TABLE_DEPTH)))
        else $error("write into a full table");

endmodule

// ===== src/tcst_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module tcst_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
